// File: rtl/core/sfe_pkg.sv
// sfe_pkg: shared types and constants for the SLIP frame encoder.
// No dependencies; imported by every module of the block.
package sfe_pkg;

  // Action codes carried on the input tuser
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_DATA  = 2'd1;
  localparam logic [1:0] ACT_END   = 2'd2;

  // SLIP special bytes
  localparam logic [7:0] FRAME_END  = 8'hC0;
  localparam logic [7:0] FRAME_ESC  = 8'hDB;
  localparam logic [7:0] ESC_OF_END = 8'hDC;
  localparam logic [7:0] ESC_OF_ESC = 8'hDD;

  // Record layout
  localparam int META_BYTES = 16;
  localparam int META_W     = META_BYTES * 8;
  localparam int META_IDX_W = $clog2(META_BYTES);
  localparam int IN_DATA_W  = 136;

  // Default depth of the front-to-back queue
  localparam int QUEUE_DEPTH_DEF = 2;

  // One classified item: a start carries the 16 metadata bytes, byte 0 first
  // in the low bits; a data item carries its payload in byte 0.
  typedef struct packed {
    logic [1:0]        kind;
    logic [META_W-1:0] bytes;
  } q_entry_t;

  // Push side of the queue
  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } q_push_t;

  // Pop side of the queue
  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

endpackage

// File: rtl/core/slip_frame_encoder.sv
// slip_frame_encoder: top level of the SLIP capture-record encoder.
// Depends on sfe_pkg, sfe_front, sfe_queue and sfe_back.
//
// Turns action beats into SLIP line bytes, one line byte per clock at best.
// A start beat (tuser 0) sends 0xC0 and then 16 metadata bytes: source
// address, destination address (both little-endian), qos, source endpoint,
// destination endpoint, rssi and delay (little-endian), each byte escaped;
// that is 17 to 33 line bytes. A data beat (tuser 1) sends its payload
// byte escaped, as 1 or 2 line bytes. An end beat (tuser 2) sends 0xC0.
// tuser 3 is accepted and produces nothing. 0xC0 goes out as 0xDB 0xDC
// and 0xDB as 0xDB 0xDD. out_tlast marks the final line byte of
// each input beat. The throughput is set by the back-end byte sequencer,
// which puts out one line byte per cycle when not stalled; the input side
// keeps accepting into a QUEUE_DEPTH-entry queue while the sequencer works,
// and the output byte sits in a register so the two sides stall on their own.
module slip_frame_encoder #(
  parameter int QUEUE_DEPTH = sfe_pkg::QUEUE_DEPTH_DEF  // 2 or more
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // tdata: source_addr[31:0], dest_addr[63:32], qos_class[71:64],
  // source_endpoint[79:72], dest_endpoint[87:80], signal_strength[95:88],
  // travel_delay[127:96], payload_byte[135:128]
  input  logic [sfe_pkg::IN_DATA_W-1:0] in_tdata,
  // tuser: action[1:0]
  input  logic [1:0]                    in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // tdata: line_byte[7:0]
  output logic [7:0]                    out_tdata,
  // tlast: run_last
  output logic                          out_tlast
);
  import sfe_pkg::*;

  q_push_t q_push;
  q_head_t q_head;
  logic    q_full;
  logic    q_pop;

  // front: classify and pack
  sfe_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push)
  );

  // decoupling queue
  sfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_pop  (q_pop),
    .q_full (q_full),
    .q_head (q_head)
  );

  // back: byte sequencer, escaping, output register
  sfe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// File: rtl/core/sfe_front.sv
// sfe_front: accepts input beats, drops undefined actions and packs the
// metadata or payload into a queue entry. Depends on sfe_pkg.
module sfe_front (
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // tdata: source_addr[31:0], dest_addr[63:32], qos_class[71:64],
  // source_endpoint[79:72], dest_endpoint[87:80], signal_strength[95:88],
  // travel_delay[127:96], payload_byte[135:128]
  input  logic [sfe_pkg::IN_DATA_W-1:0] in_tdata,
  // tuser: action[1:0]
  input  logic [1:0]                    in_tuser,
  input  logic                          q_full,
  output sfe_pkg::q_push_t              q_push
);
  import sfe_pkg::*;

  logic [31:0] source_addr, dest_addr, travel_delay;
  logic [7:0]  qos_class, source_endpoint, dest_endpoint, signal_strength, payload_byte;
  logic        known;

  assign source_addr     = in_tdata[31:0];
  assign dest_addr       = in_tdata[63:32];
  assign qos_class       = in_tdata[71:64];
  assign source_endpoint = in_tdata[79:72];
  assign dest_endpoint   = in_tdata[87:80];
  assign signal_strength = in_tdata[95:88];
  assign travel_delay    = in_tdata[127:96];
  assign payload_byte    = in_tdata[135:128];

  assign in_tready = !q_full;

  always_comb begin
    known = 1'b1;
    q_push.entry.kind  = in_tuser;
    q_push.entry.bytes = '0;
    case (in_tuser)
      ACT_START: begin
        // little-endian fields, source address byte 0 lowest
        q_push.entry.bytes = {travel_delay, signal_strength, dest_endpoint,
                              source_endpoint, qos_class, dest_addr, source_addr};
      end
      ACT_DATA: begin
        q_push.entry.bytes = {{(META_W-8){1'b0}}, payload_byte};
      end
      ACT_END: begin
        q_push.entry.bytes = '0;
      end
      default: begin
        known = 1'b0;
      end
    endcase
    q_push.push = in_tvalid && in_tready && known;
  end

endmodule

// File: rtl/core/sfe_queue.sv
// sfe_queue: small FIFO of classified items between front and back.
// Depends on sfe_pkg.
module sfe_queue #(
  parameter int DEPTH = sfe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  sfe_pkg::q_push_t q_push,
  input  logic             q_pop,
  output logic             q_full,
  output sfe_pkg::q_head_t q_head
);
  import sfe_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t         mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_pop;

  assign q_full       = (count_r == CNT_W'(DEPTH));
  assign q_head.valid = (count_r != '0);
  assign q_head.entry = mem[rd_ptr_r];
  assign do_pop       = q_pop && q_head.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (q_push.push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (q_push.push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (!q_push.push && do_pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push.push) begin
      mem[wr_ptr_r] <= q_push.entry;
    end
  end

endmodule

// File: rtl/core/sfe_back.sv
// sfe_back: walks the head queue entry byte by byte, applies SLIP escaping
// and drives the registered output stream. Depends on sfe_pkg.
module sfe_back (
  input  logic             clk,
  input  logic             rst_n,
  input  sfe_pkg::q_head_t q_head,
  output logic             q_pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,
  output logic             out_tlast
);
  import sfe_pkg::*;

  localparam int IDX_W = $clog2(META_BYTES + 1);

  logic [IDX_W-1:0]      idx_r, idx_nxt, idx_m1;
  logic                  esc_r, esc_nxt;
  logic                  ovalid_r, ovalid_nxt;
  logic [7:0]            obyte_r, obyte_nxt;
  logic                  olast_r, olast_nxt;
  logic [META_IDX_W-1:0] meta_sel;
  logic                  is_start, raw_delim, last_byte, need_esc, advance, byte_done;
  logic [7:0]            cur_byte, emit_byte;

  assign is_start  = (q_head.entry.kind == ACT_START);
  assign idx_m1    = idx_r - IDX_W'(1);
  assign meta_sel  = is_start ? idx_m1[META_IDX_W-1:0] : '0;
  assign raw_delim = (q_head.entry.kind == ACT_END) || (is_start && idx_r == '0);
  assign last_byte = is_start ? (idx_r == IDX_W'(META_BYTES)) : 1'b1;
  assign cur_byte  = q_head.entry.bytes[meta_sel*8 +: 8];
  assign need_esc  = !raw_delim && (cur_byte == FRAME_END || cur_byte == FRAME_ESC);
  assign advance   = q_head.valid && (!ovalid_r || out_tready);
  // a byte is finished when it needed no escape or its second half goes out
  assign byte_done = esc_r || !need_esc;

  always_comb begin
    if (raw_delim) begin
      emit_byte = FRAME_END;
    end else if (esc_r) begin
      emit_byte = (cur_byte == FRAME_END) ? ESC_OF_END : ESC_OF_ESC;
    end else if (need_esc) begin
      emit_byte = FRAME_ESC;
    end else begin
      emit_byte = cur_byte;
    end
  end

  always_comb begin
    idx_nxt    = idx_r;
    esc_nxt    = esc_r;
    ovalid_nxt = ovalid_r && !out_tready;
    obyte_nxt  = obyte_r;
    olast_nxt  = olast_r;
    q_pop      = 1'b0;
    if (advance) begin
      ovalid_nxt = 1'b1;
      obyte_nxt  = emit_byte;
      olast_nxt  = byte_done && last_byte;
      if (!byte_done) begin
        esc_nxt = 1'b1;
      end else begin
        esc_nxt = 1'b0;
        if (last_byte) begin
          idx_nxt = '0;
          q_pop   = 1'b1;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      esc_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      idx_r    <= idx_nxt;
      esc_r    <= esc_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    obyte_r <= obyte_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = obyte_r;
  assign out_tlast  = olast_r;

endmodule
